// ===== rtl/f2mf_pkg.sv =====
// Shared types and constants for the float to minifloat converter.
// No dependencies.
`default_nettype none

package f2mf_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned ExpCodeW  = 8;
  localparam int unsigned MantCodeW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  // Binary64 aligned fraction width; binary32 fractions are left-aligned to it.
  localparam int unsigned FracW     = 52;
  localparam int unsigned SrcExpW   = 11;
  // Signed working exponent, spans 1 - 1023 up to 2046 - 1023 + 255 + 1.
  localparam int unsigned WorkExpW  = 13;

  localparam logic [SrcExpW-1:0] Bias64 = 11'd1023;
  localparam logic [SrcExpW-1:0] Bias32 = 11'd127;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSourceIsDouble = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpWidth       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetBias     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMantWidth      = 2'd3;

  typedef struct packed {
    logic       source_is_double;
    logic [3:0] exp_width;
    logic [7:0] target_bias;
    logic [4:0] mant_width;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/f2mf_core.sv =====
// Combinational conversion of one IEEE word into minifloat fields.
// Depends on f2mf_pkg.
`default_nettype none

module f2mf_core
  import f2mf_pkg::*;
(
  input  var cfg_t                 cfg,
  input  wire logic [WordW-1:0]     word,
  output logic                      sign,
  output logic [ExpCodeW-1:0]       exp_out,
  output logic [MantCodeW-1:0]      mant_out
);

  logic [3:0]            ew;
  logic [4:0]            mw;
  logic [ExpCodeW-1:0]   emax;
  logic [SrcExpW-1:0]    e_src;
  logic [SrcExpW-1:0]    src_bias;
  logic [FracW-1:0]      frac;
  logic                  e_zero;
  logic                  e_ones;
  logic [3:0]            top_sh;
  logic [MantCodeW-1:0]  top;
  logic [5:0]            gpos;
  logic                  guard;
  logic [FracW-1:0]      below_mask;
  logic                  sticky;
  logic                  rnd_inc;
  logic [MantCodeW:0]    rounded;
  logic                  carry;
  logic [WorkExpW-1:0]   e_new;
  logic                  e_le0;
  logic                  e_ovf;

  always_comb begin
    if (cfg.exp_width == 4'd0) begin
      ew = 4'd1;
    end else if (cfg.exp_width > 4'd8) begin
      ew = 4'd8;
    end else begin
      ew = cfg.exp_width;
    end
    if (cfg.mant_width == 5'd0) begin
      mw = 5'd1;
    end else if (cfg.mant_width > 5'd16) begin
      mw = 5'd16;
    end else begin
      mw = cfg.mant_width;
    end
  end

  assign emax = ExpCodeW'((9'd1 << ew) - 9'd1);

  always_comb begin
    if (cfg.source_is_double) begin
      sign     = word[63];
      e_src    = word[62:52];
      frac     = word[51:0];
      src_bias = Bias64;
    end else begin
      sign     = word[31];
      e_src    = {3'b000, word[30:23]};
      frac     = {word[22:0], 29'd0};
      src_bias = Bias32;
    end
  end

  assign e_zero = (e_src == '0);
  assign e_ones = cfg.source_is_double ? (&e_src) : (&e_src[7:0]);

  // Round to nearest even on the top mw bits of the aligned fraction.
  assign top_sh     = 4'(5'd16 - mw);
  assign top        = frac[51:36] >> top_sh;
  assign gpos       = 6'(6'd51 - {1'b0, mw});
  assign guard      = frac[gpos];
  assign below_mask = FracW'((53'd1 << gpos) - 53'd1);
  assign sticky     = |(frac & below_mask);
  assign rnd_inc    = guard && (sticky || top[0]);
  assign rounded    = {1'b0, top} + {{MantCodeW{1'b0}}, rnd_inc};
  assign carry      = rounded[mw];

  assign e_new = WorkExpW'(e_src) - WorkExpW'(src_bias)
               + WorkExpW'(cfg.target_bias) + WorkExpW'(carry);
  assign e_le0 = e_new[WorkExpW-1] || (e_new == '0);
  assign e_ovf = !e_new[WorkExpW-1] && (e_new >= WorkExpW'(emax));

  always_comb begin
    if (e_zero) begin
      exp_out  = '0;
      mant_out = '0;
    end else if (e_ones) begin
      exp_out  = emax;
      mant_out = (frac != '0) ? MantCodeW'(1) : '0;
    end else if (e_le0) begin
      exp_out  = '0;
      mant_out = '0;
    end else if (e_ovf) begin
      exp_out  = emax;
      mant_out = '0;
    end else begin
      exp_out  = e_new[ExpCodeW-1:0];
      mant_out = carry ? '0 : rounded[MantCodeW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/float_to_minifloat_round.sv =====
// Top level: IEEE binary32/binary64 to configurable minifloat, RNE rounding.
// A request passes through the input register and then the result register.
// Throughput one request per cycle while out_ready stays high; the rate is set by the single conversion stage.
// rst (synchronous) empties both stages and loads the register defaults:
// binary32 source, exponent width 4, bias 7, mantissa width 16.
// Depends on f2mf_pkg and f2mf_core.
`default_nettype none

module float_to_minifloat_round
  import f2mf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [WordW-1:0]      raw_word,
  input  wire logic                  end_of_array,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       sign_bit,
  output logic [ExpCodeW-1:0]        exp_code,
  output logic [MantCodeW-1:0]       mant_code,
  output logic                       end_out
);

  cfg_t                 cfg;
  logic                 s1_valid;
  logic [WordW-1:0]     s1_word;
  logic                 s1_end;
  logic                 out_load;
  logic                 conv_sign;
  logic [ExpCodeW-1:0]  conv_exp;
  logic [MantCodeW-1:0] conv_mant;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_is_double <= 1'b0;
      cfg.exp_width        <= 4'd4;
      cfg.target_bias      <= 8'd7;
      cfg.mant_width       <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSourceIsDouble: cfg.source_is_double <= cfg_data[0];
        CfgExpWidth:       cfg.exp_width        <= cfg_data[3:0];
        CfgTargetBias:     cfg.target_bias      <= cfg_data;
        CfgMantWidth:      cfg.mant_width       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= raw_word;
      s1_end  <= end_of_array;
    end
  end

  f2mf_core u_core (
    .cfg      (cfg),
    .word     (s1_word),
    .sign     (conv_sign),
    .exp_out  (conv_exp),
    .mant_out (conv_mant)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sign_bit  <= conv_sign;
      exp_code  <= conv_exp;
      mant_code <= conv_mant;
      end_out   <= s1_end;
    end
  end

  // A nonzero mantissa never comes with a zero exponent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (mant_code != '0) |-> (exp_code != '0))
    else $error("nonzero mantissa with zero exponent");

  // An accepted request always lands in the input stage.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request lost");

  // A held input stage waits while the result register is blocked.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid && $stable(s1_word))
    else $error("input stage dropped while stalled");

  // Reset empties both stages.
  assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for float_to_minifloat_round: random and corner IEEE words,
// predicted sign/exponent/mantissa codes compared against every result request.
// Depends on f2mf_pkg and the float_to_minifloat_round RTL.
`default_nettype none

module testbench
  import f2mf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned RandPerPhase = 215;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } float_req_t;

  typedef struct packed {
    logic                 sign_bit;
    logic [ExpCodeW-1:0]  exp_code;
    logic [MantCodeW-1:0] mant_code;
    logic                 end_out;
  } mf_code_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WordW-1:0]     raw_word = '0;
  logic                 end_of_array = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 sign_bit;
  logic [ExpCodeW-1:0]  exp_code;
  logic [MantCodeW-1:0] mant_code;
  logic                 end_out;

  float_to_minifloat_round i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .raw_word     (raw_word),
    .end_of_array (end_of_array),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sign_bit     (sign_bit),
    .exp_code     (exp_code),
    .mant_code    (mant_code),
    .end_out      (end_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register image as the block holds it; starts at the reset values.
  cfg_t mf_cfg = '{1'b0, 4'd4, 8'd7, 5'd16};

  float_req_t  pending_words[$];
  mf_code_t    expected_codes[$];
  float_req_t  next_word;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cnt = 0;
  logic        hold_go = 1'b0;

  function automatic int eff_exp_width();
    if (mf_cfg.exp_width == 0) return 1;
    if (mf_cfg.exp_width > 8) return 8;
    return int'(mf_cfg.exp_width);
  endfunction

  function automatic int eff_mant_width();
    if (mf_cfg.mant_width == 0) return 1;
    if (mf_cfg.mant_width > 16) return 16;
    return int'(mf_cfg.mant_width);
  endfunction

  function automatic mf_code_t minifloat_of(logic [WordW-1:0] w, logic last);
    int          ew, mw, emax, e_src, e_all, src_bias, fbits, sh, e;
    logic [63:0] frac, top, rem, half, r;
    logic        up;
    mf_code_t    res;
    ew = eff_exp_width();
    mw = eff_mant_width();
    emax = (1 << ew) - 1;
    if (mf_cfg.source_is_double) begin
      res.sign_bit = w[63];
      e_src = int'(w[62:52]);
      frac = {12'd0, w[51:0]};
      e_all = 2047;
      src_bias = 1023;
      fbits = 52;
    end else begin
      res.sign_bit = w[31];
      e_src = int'(w[30:23]);
      frac = {41'd0, w[22:0]};
      e_all = 255;
      src_bias = 127;
      fbits = 23;
    end
    res.exp_code = '0;
    res.mant_code = '0;
    res.end_out = last;
    if (e_src == 0) begin
      // zero and subnormals flush, sign kept
    end else if (e_src == e_all) begin
      res.exp_code = emax[ExpCodeW-1:0];
      res.mant_code = (frac != 0) ? 16'd1 : 16'd0;
    end else begin
      sh = fbits - mw;
      top = frac >> sh;
      rem = frac & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      up = (rem > half) || (rem == half && top[0]);
      r = top + {63'd0, up};
      e = e_src - src_bias + int'(mf_cfg.target_bias);
      if (r >= (64'd1 << mw)) begin
        r = '0;
        e++;
      end
      if (e <= 0) begin
        res.exp_code = '0;
      end else if (e >= emax) begin
        res.exp_code = emax[ExpCodeW-1:0];
      end else begin
        res.exp_code = e[ExpCodeW-1:0];
        res.mant_code = r[MantCodeW-1:0];
      end
    end
    return res;
  endfunction

  // Mostly exponents near the target range, with rounding ties and carries.
  function automatic logic [WordW-1:0] random_float_word();
    int          emax, e_all, src_bias, fbits, sh, e_src, pick;
    logic [63:0] w, frac, rmask, half;
    w = {$urandom, $urandom};
    emax = (1 << eff_exp_width()) - 1;
    if (mf_cfg.source_is_double) begin
      e_all = 2047;
      src_bias = 1023;
      fbits = 52;
    end else begin
      e_all = 255;
      src_bias = 127;
      fbits = 23;
    end
    pick = int'($urandom_range(99));
    if (pick < 8) begin
      e_src = 0;
    end else if (pick < 14) begin
      e_src = e_all;
    end else if (pick < 24) begin
      e_src = int'($urandom_range(e_all));
    end else begin
      e_src = int'($urandom_range(emax + 2)) - 1 + src_bias - int'(mf_cfg.target_bias);
      if (e_src < 1) e_src = 1;
      if (e_src > e_all - 1) e_src = e_all - 1;
    end
    frac = w & ((64'd1 << fbits) - 64'd1);
    sh = fbits - eff_mant_width();
    rmask = (64'd1 << sh) - 64'd1;
    half = 64'd1 << (sh - 1);
    case ($urandom_range(5))
      0: frac = (frac & ~rmask) | half;
      1: frac = frac | (((64'd1 << fbits) - 64'd1) & ~rmask);
      2: frac = (frac & ~rmask) | (($urandom_range(1) != 0) ? half + 64'd1 : half - 64'd1);
      default: ;
    endcase
    if (mf_cfg.source_is_double) begin
      w[62:52] = e_src[10:0];
      w[51:0] = frac[51:0];
    end else begin
      w[30:23] = e_src[7:0];
      w[22:0] = frac[22:0];
    end
    return w;
  endfunction

  task automatic push_word(input logic [WordW-1:0] w, input logic last);
    pending_words.push_back('{w, last});
  endtask

  task automatic set_config(input cfg_t c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgSourceIsDouble;
    cfg_data <= {7'd0, c.source_is_double};
    @(posedge clk);
    cfg_index <= CfgExpWidth;
    cfg_data <= {4'd0, c.exp_width};
    @(posedge clk);
    cfg_index <= CfgTargetBias;
    cfg_data <= c.target_bias;
    @(posedge clk);
    cfg_index <= CfgMantWidth;
    cfg_data <= {3'd0, c.mant_width};
    @(posedge clk);
    cfg_we <= 1'b0;
    mf_cfg = c;
  endtask

  // Driver: predicts at acceptance, then offers the next pending word.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_codes.push_back(minifloat_of(raw_word, end_of_array));
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        raw_word <= next_word.word;
        end_of_array <= next_word.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result request against the oldest prediction.
  always @(posedge clk) begin
    mf_code_t want, got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{sign_bit, exp_code, mant_code, end_out};
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t unexpected result %h", $realtime, got);
        end else begin
          want = expected_codes.pop_front();
          if (got.sign_bit !== want.sign_bit || got.exp_code !== want.exp_code ||
              got.mant_code !== want.mant_code || got.end_out !== want.end_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch exp/act: sign %b/%b exp %h/%h mant %h/%h end %b/%b",
                       $realtime, want.sign_bit, got.sign_bit, want.exp_code, got.exp_code,
                       want.mant_code, got.mant_code, want.end_out, got.end_out);
          end
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the pipeline backs up into in_ready.
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_go) hold_cnt <= 300;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t phase_cfg [NumPhases];
    phase_cfg[0] = '{1'b0, 4'd4, 8'd7, 5'd16};
    phase_cfg[1] = '{1'b1, 4'd11, 8'd15, 5'd10};
    phase_cfg[2] = '{1'b0, 4'd8, 8'd127, 5'd16};
    phase_cfg[3] = '{1'b1, 4'd1, 8'd0, 5'd1};
    phase_cfg[4] = '{1'b0, 4'd0, 8'd255, 5'd0};
    phase_cfg[5] = '{1'b1, 4'd8, 8'd255, 5'd31};
    phase_cfg[6] = '{1'b0, 4'd15, 8'd1, 5'd23};
    phase_cfg[7] = '{1'b1, 4'd5, 8'd15, 5'd2};
    phase_cfg[8] = cfg_t'(18'($urandom));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) set_config(phase_cfg[p]);
      case (p / 3)
        0: begin send_idle_pct = 31; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 0) begin
        // binary32, E=4 bias 7 M=16; upper word garbage must be ignored
        push_word(64'h0000_0000_0000_0000, 1'b0);
        push_word(64'hDEAD_BEEF_8000_0000, 1'b1);
        push_word(64'hFFFF_FFFF_0000_0001, 1'b0);
        push_word(64'h0000_0000_807F_FFFF, 1'b0);
        push_word(64'h1234_5678_7F80_0000, 1'b1);
        push_word(64'h0000_0000_FF80_0000, 1'b0);
        push_word(64'h0000_0000_7FC0_0000, 1'b0);
        push_word(64'h0000_0000_7F80_0001, 1'b0);
        push_word(64'h0000_0000_3F80_0000, 1'b0);
        push_word(64'h0000_0000_7F7F_FFFF, 1'b0);
        push_word(64'h0000_0000_3C00_0000, 1'b0);
        push_word(64'h0000_0000_3C80_0000, 1'b0);
        push_word(64'h0000_0000_3F80_0040, 1'b0);
        push_word(64'h0000_0000_3F80_00C0, 1'b0);
        push_word(64'h0000_0000_3FFF_FFFF, 1'b0);
        push_word(64'h0000_0000_4300_0000, 1'b0);
        push_word(64'h0000_0000_437F_FFFF, 1'b1);
      end else if (p == 1) begin
        // binary64, E clamps to 8, bias 15, M=10
        push_word(64'h0000_0000_0000_0000, 1'b0);
        push_word(64'h800F_FFFF_FFFF_FFFF, 1'b0);
        push_word(64'h7FF0_0000_0000_0000, 1'b1);
        push_word(64'h7FF8_0000_0000_0000, 1'b0);
        push_word(64'hFFF0_0000_0000_0001, 1'b0);
        push_word(64'h3FF0_0000_0000_0000, 1'b0);
        push_word(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        push_word(64'h0010_0000_0000_0000, 1'b0);
        push_word(64'h3FF0_0200_0000_0000, 1'b0);
        push_word(64'h3FF0_0600_0000_0000, 1'b0);
        push_word(64'h3FFF_FFFF_FFFF_FFFF, 1'b0);
        push_word(64'h3F00_0000_0000_0000, 1'b0);
        push_word(64'h3F10_0000_0000_0000, 1'b1);
      end
      for (int n = 0; n < RandPerPhase; n++)
        push_word(random_float_word(), $urandom_range(1) == 1);
      if (p == 7) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      while (pending_words.size() != 0 || in_valid || expected_codes.size() != 0)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end

    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
